FILE: rtl/label_size_filter_renumber_defines.svh
// Assertion macros used by the port-level checker of the label size filter.
// Needs nothing else; include by bare file name.
`ifndef LABEL_SIZE_FILTER_RENUMBER_DEFINES_SVH
`define LABEL_SIZE_FILTER_RENUMBER_DEFINES_SVH

// Same-cycle implication under active-low reset.
`define LSFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication under active-low reset.
`define LSFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/lsfr_pkg.sv
// Shared types and constants of the label size filter.
// Used by the controller, the datapath, the top level and the checker.
package lsfr_pkg;

  localparam int unsigned NUM_LABELS_DEF = 4096;
  localparam int unsigned COUNT_BITS_DEF = 32;

  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned LABEL_W     = 12;
  localparam int unsigned NEW_LABEL_W = 12;
  localparam int unsigned SIZE_W      = 32;
  localparam int unsigned KEPT_W      = 13;
  // wide enough to hold the largest label count itself
  localparam int unsigned LABEL_EXT_W = 17;
  localparam int unsigned CFG_W       = 32;
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned S_TDATA_W   = 16;
  localparam int unsigned M_TDATA_W   = 48;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_COUNT = 2'd0,
    FUNC_RANK  = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  // register index taken from paddr[2]
  localparam logic REG_MAX_SIZE = 1'b0;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic exec;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic exec_ok;
  } ctl_sts_t;

endpackage

FILE: rtl/lsfr_ctrl.sv
// Sequencer of the label size filter: clearing pass, accept, execute.
// Depends on lsfr_pkg for the command and status structs.
module lsfr_ctrl import lsfr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_tvalid_i,
  output logic     s_tready_o,
  output ctl_cmd_t cmd_o,
  input  ctl_sts_t sts_i
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   tready_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid_i && tready_q) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        // hold while a query waits for the output register
        if (sts_i.exec_ok) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o.clr_step = (state_q == ST_CLEAR);
    cmd_o.load     = tready_q && s_tvalid_i;
    cmd_o.exec     = (state_q == ST_EXEC) && sts_i.exec_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      tready_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      tready_q <= (state_d == ST_IDLE);
    end
  end

  assign s_tready_o = tready_q;

endmodule

FILE: rtl/lsfr_datapath.sv
// Datapath of the label size filter: size and renumber tables, running
// kept count, output register. Depends on lsfr_pkg.
module lsfr_datapath import lsfr_pkg::*; #(
  parameter int unsigned NUM_LABELS = NUM_LABELS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ctl_cmd_t               cmd_i,
  output ctl_sts_t               sts_o,
  input  logic [FUNC_W-1:0]      func_i,
  input  logic [LABEL_W-1:0]     label_id_i,
  input  logic [CFG_W-1:0]       max_size_i,
  input  logic                   m_tready_i,
  output logic                   m_tvalid_o,
  output logic                   removed_o,
  output logic [NEW_LABEL_W-1:0] new_label_o,
  output logic [SIZE_W-1:0]      region_size_o
);

  localparam int unsigned IDX_W = (NUM_LABELS > 1) ? $clog2(NUM_LABELS) : 1;
  localparam int unsigned EXT_W = (COUNT_BITS > SIZE_W) ? COUNT_BITS : SIZE_W;

  logic [COUNT_BITS-1:0]  size_mem  [NUM_LABELS];
  logic [NEW_LABEL_W-1:0] renum_mem [NUM_LABELS];

  logic [LABEL_EXT_W-1:0] label_ext;
  logic                   in_valid;
  logic [IDX_W-1:0]       in_addr;

  func_e                  func_q;
  logic                   valid_q;
  logic [IDX_W-1:0]       addr_q;
  logic [COUNT_BITS-1:0]  size_rd_q;
  logic [NEW_LABEL_W-1:0] renum_rd_q;
  logic [KEPT_W-1:0]      kept_q, kept_d, kept_base;
  logic [IDX_W-1:0]       clr_cnt_q;

  logic                   out_valid_q;
  logic                   out_removed_q;
  logic [NEW_LABEL_W-1:0] out_new_q;
  logic [SIZE_W-1:0]      out_size_q;

  logic [EXT_W-1:0]       cnt_ext;
  logic                   drop_lab;
  logic [SIZE_W-1:0]      size_sat;
  logic                   size_we, renum_we, out_load;
  logic [IDX_W-1:0]       size_wa;
  logic [COUNT_BITS-1:0]  size_wd;
  logic [NEW_LABEL_W-1:0] renum_wd;

  assign label_ext = LABEL_EXT_W'(label_id_i);
  assign in_valid  = label_ext < LABEL_EXT_W'(NUM_LABELS);
  assign in_addr   = label_ext[IDX_W-1:0];

  // word capture and table read
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q     <= func_e'(func_i);
      valid_q    <= in_valid;
      addr_q     <= in_addr;
      size_rd_q  <= size_mem[in_addr];
      renum_rd_q <= renum_mem[in_addr];
    end
  end

  assign cnt_ext  = EXT_W'(size_rd_q);
  assign drop_lab = (size_rd_q != '0) && (cnt_ext <= EXT_W'(max_size_i));
  assign size_sat = (cnt_ext > EXT_W'({SIZE_W{1'b1}})) ? {SIZE_W{1'b1}}
                                                      : cnt_ext[SIZE_W-1:0];

  // label zero restarts the compact numbering
  assign kept_base = (addr_q == '0) ? '0 : kept_q;

  always_comb begin
    size_we  = cmd_i.clr_step ||
               (cmd_i.exec && (func_q == FUNC_COUNT) && valid_q && (size_rd_q != '1));
    size_wa  = cmd_i.clr_step ? clr_cnt_q : addr_q;
    size_wd  = cmd_i.clr_step ? '0 : size_rd_q + COUNT_BITS'(1);
    renum_we = cmd_i.exec && (func_q == FUNC_RANK) && valid_q;
    renum_wd = drop_lab ? '0 : kept_base[NEW_LABEL_W-1:0];
    kept_d   = kept_q;
    if (renum_we) begin
      kept_d = drop_lab ? kept_base : kept_base + KEPT_W'(1);
    end
    out_load = cmd_i.exec && (func_q == FUNC_QUERY);
  end

  always_ff @(posedge clk_i) begin
    if (size_we) size_mem[size_wa] <= size_wd;
    if (renum_we) renum_mem[addr_q] <= renum_wd;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_removed_q <= valid_q && drop_lab;
      out_new_q     <= (valid_q && !drop_lab) ? renum_rd_q : '0;
      out_size_q    <= valid_q ? size_sat : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_q      <= '0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      kept_q <= kept_d;
      if (cmd_i.clr_step) clr_cnt_q <= clr_cnt_q + IDX_W'(1);
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.clr_last = (clr_cnt_q == IDX_W'(NUM_LABELS - 1));
  assign sts_o.exec_ok  = (func_q != FUNC_QUERY) || !out_valid_q || m_tready_i;

  assign m_tvalid_o    = out_valid_q;
  assign removed_o     = out_removed_q;
  assign new_label_o   = out_new_q;
  assign region_size_o = out_size_q;

endmodule

FILE: rtl/label_size_filter_renumber.sv
// A word is accepted, its tables are read, then the execute state writes
// a table or loads a query result into the output register; no new word is
// taken before that is done, and a query waits while a finished result is not taken.
// Reset: asynchronous, active low; afterwards a clearing pass over all NUM_LABELS
// entries zeroes the size table with s_axis_tready_o low; config stays open.
// Depends on lsfr_pkg, lsfr_ctrl and lsfr_datapath.
module label_size_filter_renumber import lsfr_pkg::*; #(
  parameter int unsigned NUM_LABELS = NUM_LABELS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,  // func[1:0], label_id[13:2], zero pad
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,  // removed[0], new_label[12:1],
                                                // region_size[44:13], zero pad
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [CFG_W-1:0]     pwdata,
  output logic [CFG_W-1:0]     prdata,
  output logic                 pready
);

  ctl_cmd_t               cmd;
  ctl_sts_t               sts;
  logic [CFG_W-1:0]       max_size_q;
  logic                   cfg_wr;
  logic                   removed;
  logic [NEW_LABEL_W-1:0] new_label;
  logic [SIZE_W-1:0]      region_size;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_SIZE);
  assign prdata = (paddr[2] == REG_MAX_SIZE) ? max_size_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_size_q <= '0;
    end else if (cfg_wr) begin
      max_size_q <= pwdata;
    end
  end

  lsfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  lsfr_datapath #(
    .NUM_LABELS (NUM_LABELS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .func_i        (s_axis_tdata_i[FUNC_W-1:0]),
    .label_id_i    (s_axis_tdata_i[FUNC_W+LABEL_W-1:FUNC_W]),
    .max_size_i    (max_size_q),
    .m_tready_i    (m_axis_tready_i),
    .m_tvalid_o    (m_axis_tvalid_o),
    .removed_o     (removed),
    .new_label_o   (new_label),
    .region_size_o (region_size)
  );

  assign m_axis_tdata_o = {{(M_TDATA_W-1-NEW_LABEL_W-SIZE_W){1'b0}},
                           region_size, new_label, removed};

endmodule

FILE: rtl/lsfr_checker.sv
// Port-level checks of the label size filter, bound to the top level.
// Depends on lsfr_pkg and label_size_filter_renumber_defines.svh.
`include "label_size_filter_renumber_defines.svh"

module lsfr_checker import lsfr_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid_i,
  input logic                 s_axis_tready_o,
  input logic [S_TDATA_W-1:0] s_axis_tdata_i,
  input logic                 m_axis_tvalid_o,
  input logic                 m_axis_tready_i,
  input logic [M_TDATA_W-1:0] m_axis_tdata_o,
  input logic                 psel,
  input logic                 penable,
  input logic                 pwrite,
  input logic [PADDR_W-1:0]   paddr,
  input logic [CFG_W-1:0]     pwdata,
  input logic [CFG_W-1:0]     prdata,
  input logic                 pready
);

  // one word in flight: no accept in the cycle after an accept
  `LSFR_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)

  // only a query word raises the result valid
  `LSFR_ASSERT_IMP(a_no_spurious_result, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o && (s_axis_tdata_i[FUNC_W-1:0] != FUNC_QUERY), ##2 !$rose(m_axis_tvalid_o))

  // threshold reads back what was written
  `LSFR_ASSERT_NEXT(a_cfg_readback, clk_i, rst_ni, psel && penable && pwrite && pready && (paddr[2] == REG_MAX_SIZE), (paddr[2] != REG_MAX_SIZE) || (prdata == $past(pwdata)))

  // a stalled result holds
  `LSFR_ASSERT_NEXT(a_result_holds, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o))

endmodule

bind label_size_filter_renumber lsfr_checker u_lsfr_checker (.*);

FILE: sim/lsfr_checker.sv
// Scoreboard for the label size filter: watches the word, result and register
// ports, predicts each query result from its own tables and compares fields.
// Depends on lsfr_pkg.
module lsfr_scoreboard import lsfr_pkg::*; #(
  parameter int unsigned NUM_LABELS = NUM_LABELS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  input  logic                 s_ready_i,
  input  logic [S_TDATA_W-1:0] s_data_i,
  input  logic                 m_valid_i,
  input  logic                 m_ready_i,
  input  logic [M_TDATA_W-1:0] m_data_i,
  input  logic                 psel_i,
  input  logic                 penable_i,
  input  logic                 pwrite_i,
  input  logic                 pready_i,
  input  logic [PADDR_W-1:0]   paddr_i,
  input  logic [CFG_W-1:0]     pwdata_i,
  input  logic [CFG_W-1:0]     prdata_i,
  output int                   mismatch_o,
  output int                   pending_o,
  output int                   checked_o,
  output int                   removed_o
);

  typedef struct packed {
    logic                   removed;
    logic [NEW_LABEL_W-1:0] new_label;
    logic [SIZE_W-1:0]      region_size;
  } lookup_t;

  localparam logic [63:0] COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;

  logic [63:0]            hist_cnt [NUM_LABELS];
  logic [NEW_LABEL_W-1:0] compact_idx [NUM_LABELS];
  logic [KEPT_W-1:0]      kept_total;
  logic [CFG_W-1:0]       size_limit;
  lookup_t                lookup_q [$];
  int                     mismatches;
  int                     checked;
  int                     removed_seen;

  function automatic bit is_small(logic [63:0] cnt);
    return cnt != 64'd0 && cnt <= {32'd0, size_limit};
  endfunction

  function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] %s mismatch: expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  // Update histogram and index tables for one word; queue the lookup of a query.
  function automatic void apply_word(func_e f, logic [LABEL_W-1:0] lab);
    lookup_t res;
    bit      in_range;
    in_range = lab < NUM_LABELS;
    case (f)
      FUNC_COUNT: begin
        if (in_range && hist_cnt[lab] < COUNT_MAX)
          hist_cnt[lab] += 64'd1;
      end
      FUNC_RANK: begin
        if (in_range) begin
          // label zero starts a new ranking pass
          if (lab == '0)
            kept_total = '0;
          if (is_small(hist_cnt[lab])) begin
            compact_idx[lab] = '0;
          end else begin
            compact_idx[lab] = kept_total[NEW_LABEL_W-1:0];
            kept_total += 1'b1;
          end
        end
      end
      FUNC_QUERY: begin
        res = '0;
        if (in_range) begin
          if (is_small(hist_cnt[lab]))
            res.removed = 1'b1;
          else
            res.new_label = compact_idx[lab];
          res.region_size = (hist_cnt[lab] > 64'hFFFF_FFFF) ? '1
                                                            : hist_cnt[lab][SIZE_W-1:0];
        end
        lookup_q = {lookup_q, res};
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_t want;
    lookup_t got;
    if (!rst_ni) begin
      foreach (hist_cnt[i])
        hist_cnt[i] = '0;
      kept_total   = '0;
      size_limit   = '0;
      lookup_q.delete();
      mismatches   = 0;
      checked      = 0;
      removed_seen = 0;
    end else begin
      if (psel_i && penable_i && pready_i && paddr_i[2] == REG_MAX_SIZE) begin
        if (pwrite_i)
          size_limit = pwdata_i;
        else
          check_field("max_region_size readback", size_limit, prdata_i);
      end
      if (s_valid_i && s_ready_i)
        apply_word(func_e'(s_data_i[FUNC_W-1:0]), s_data_i[FUNC_W +: LABEL_W]);
      if (m_valid_i && m_ready_i) begin
        got.removed     = m_data_i[0];
        got.new_label   = m_data_i[1 +: NEW_LABEL_W];
        got.region_size = m_data_i[1+NEW_LABEL_W +: SIZE_W];
        if (lookup_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] result word %0h arrived with no query pending", $time, m_data_i);
        end else begin
          want = lookup_q.pop_front();
          check_field("removed", want.removed, got.removed);
          check_field("new_label", want.new_label, got.new_label);
          check_field("region_size", want.region_size, got.region_size);
          checked++;
          if (want.removed)
            removed_seen++;
        end
      end
    end
    mismatch_o <= mismatches;
    pending_o  <= lookup_q.size();
    checked_o  <= checked;
    removed_o  <= removed_seen;
  end

endmodule

FILE: sim/tb_top.sv
// Top of the label size filter testbench: clock, reset, word and register
// stimulus, result-side stalls and the verdict.
// Depends on lsfr_pkg, label_size_filter_renumber and lsfr_scoreboard.
module tb_top;
  import lsfr_pkg::*;

  localparam int unsigned WORD_TARGET = 1850;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE      = 8;
  localparam logic [PADDR_W-1:0] MAX_SIZE_ADDR = {REG_MAX_SIZE, 2'b00};

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_valid;
  logic                 s_ready;
  logic [S_TDATA_W-1:0] s_data;
  logic                 m_valid;
  logic                 m_ready;
  logic [M_TDATA_W-1:0] m_data;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [CFG_W-1:0]     pwdata;
  logic [CFG_W-1:0]     prdata;
  logic                 pready;

  int mismatches;
  int pending;
  int checked;
  int removed_seen;
  int words_sent;
  int cfg_writes;
  bit calm;
  bit hold_req;

  bit                 label_ranked [NUM_LABELS_DEF];
  logic [LABEL_W-1:0] ranked_list [$];

  label_size_filter_renumber #(
    .NUM_LABELS(NUM_LABELS_DEF),
    .COUNT_BITS(COUNT_BITS_DEF)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  lsfr_scoreboard #(
    .NUM_LABELS(NUM_LABELS_DEF),
    .COUNT_BITS(COUNT_BITS_DEF)
  ) SCB (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_valid),
    .s_ready_i  (s_ready),
    .s_data_i   (s_data),
    .m_valid_i  (m_valid),
    .m_ready_i  (m_ready),
    .m_data_i   (m_data),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .pready_i   (pready),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .prdata_i   (prdata),
    .mismatch_o (mismatches),
    .pending_o  (pending),
    .checked_o  (checked),
    .removed_o  (removed_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off to back up the block.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    m_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= calm || ($urandom_range(0, 99) >= 6);
      end
    end
  end

  task automatic push_word(func_e f, logic [LABEL_W-1:0] lab);
    if (f == FUNC_RANK && !label_ranked[lab]) begin
      label_ranked[lab] = 1'b1;
      ranked_list = {ranked_list, lab};
    end
    if (!calm && $urandom_range(0, 99) < 6) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {{(S_TDATA_W-FUNC_W-LABEL_W){1'b0}}, lab, f};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    if (f != FUNC_NOP)
      words_sent++;
  endtask

  // Out-of-sequence word; queries only ever hit labels that were ranked.
  task automatic push_noise();
    logic [LABEL_W-1:0] lab;
    lab = LABEL_W'($urandom_range(0, NUM_LABELS_DEF - 1));
    case ($urandom_range(0, 3))
      0: push_word(FUNC_COUNT, lab);
      1: push_word(FUNC_RANK, lab);
      2: begin
        if (ranked_list.size() > 0)
          push_word(FUNC_QUERY, ranked_list[$urandom_range(0, ranked_list.size() - 1)]);
        else
          push_word(FUNC_NOP, lab);
      end
      default: push_word(FUNC_NOP, lab);
    endcase
  endtask

  // Hold the input until every query has been answered and the pipe is quiet.
  task automatic drain();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic apb_access(bit wr, logic [CFG_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= MAX_SIZE_ADDR;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
  endtask

  task automatic set_limit(logic [CFG_W-1:0] lim);
    apb_access(1'b1, lim);
    apb_access(1'b0, '0);
    psel    <= 1'b0;
    penable <= 1'b0;
    cfg_writes++;
  endtask

  // Histogram build, ascending rank pass from label zero, then lookups.
  task automatic run_episode(int n_lab, int stride, bit hold_now);
    logic [LABEL_W-1:0] labs [$];
    int                 n_cnt;
    int                 n_q;
    int unsigned        r;
    for (int i = 0; i < n_lab; i++)
      labs = {labs, LABEL_W'(i * stride)};
    n_cnt = $urandom_range(n_lab, 4 * n_lab + 20);
    repeat (n_cnt) begin
      r = $urandom_range(0, 99);
      if (r < 8)
        push_noise();
      else if (r < 55)
        push_word(FUNC_COUNT, labs[$urandom_range(0, (n_lab - 1) / 3)]);
      else
        push_word(FUNC_COUNT, labs[$urandom_range(0, n_lab - 1)]);
    end
    foreach (labs[i]) begin
      if ($urandom_range(0, 99) < 5)
        push_noise();
      push_word(FUNC_RANK, labs[i]);
    end
    if (hold_now)
      hold_req = 1'b1;
    n_q = $urandom_range(n_lab, 3 * n_lab + 10);
    repeat (n_q) begin
      r = $urandom_range(0, 99);
      if (r < 6)
        push_noise();
      else if (r < 14)
        push_word(FUNC_COUNT, labs[$urandom_range(0, n_lab - 1)]);
      else
        push_word(FUNC_QUERY, labs[$urandom_range(0, n_lab - 1)]);
    end
    drain();
  endtask

  initial begin
    int               ep;
    int               n_lab;
    int               stride;
    logic [CFG_W-1:0] lim;
    rst_ni     <= 1'b0;
    s_valid    <= 1'b0;
    s_data     <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    words_sent = 0;
    cfg_writes = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset value reads back as zero, then a threshold of two
    apb_access(1'b0, '0);
    set_limit(32'd2);

    push_word(FUNC_COUNT, 12'h000);
    repeat (3) push_word(FUNC_COUNT, 12'hFFF);
    repeat (2) push_word(FUNC_COUNT, 12'h005);
    push_word(FUNC_COUNT, 12'hAAA);
    push_word(FUNC_COUNT, 12'h555);
    push_word(FUNC_NOP, 12'hFFF);
    push_word(FUNC_RANK, 12'h000);
    push_word(FUNC_RANK, 12'h005);
    push_word(FUNC_RANK, 12'h007);
    push_word(FUNC_RANK, 12'h555);
    push_word(FUNC_RANK, 12'hAAA);
    push_word(FUNC_RANK, 12'hFFF);
    push_word(FUNC_QUERY, 12'h000);
    push_word(FUNC_QUERY, 12'h005);
    push_word(FUNC_QUERY, 12'h007);
    // counts after ranking: decision follows the live count, index stays stored
    push_word(FUNC_COUNT, 12'h005);
    push_word(FUNC_QUERY, 12'h005);
    push_word(FUNC_COUNT, 12'h007);
    push_word(FUNC_QUERY, 12'h007);
    push_word(FUNC_QUERY, 12'hFFF);
    push_word(FUNC_QUERY, 12'hAAA);
    drain();

    ep = 0;
    while (words_sent < WORD_TARGET) begin
      case (ep % 8)
        0:       lim = '0;
        1:       lim = '1;
        3:       lim = $urandom();
        default: lim = $urandom_range(1, 10);
      endcase
      set_limit(lim);
      calm = (ep == 3 || ep == 4);
      if (ep == 2) begin
        n_lab  = 30;
        stride = 1;
      end else if (ep % 4 == 3) begin
        // few labels spread over the whole label range
        n_lab  = $urandom_range(3, 8);
        stride = $urandom_range(1, (NUM_LABELS_DEF - 1) / (n_lab - 1));
      end else begin
        n_lab  = $urandom_range(2, 40);
        stride = 1;
      end
      run_episode(n_lab, stride, ep == 2);
      ep++;
    end
    calm = 1'b0;

    $display("Run covered %0d words in %0d episodes under %0d threshold settings;",
             words_sent, ep + 1, cfg_writes);
    $display("%0d query results checked, %0d of them removed, %0d mismatches.",
             checked, removed_seen, mismatches);
    if (mismatches == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
